@@ design/assert_macros.svh @@
// Assertion helpers for the equalizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define HEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`endif

@@ design/heq_pkg.sv @@
// ----------------------------------------------------------------------------
// heq_pkg
// Types and constants of the RGB histogram equalizer.
// ----------------------------------------------------------------------------
package heq_pkg;

  localparam int unsigned NumChan = 3;
  localparam int unsigned LvlW    = 8;
  localparam int unsigned Levels  = 256;
  localparam int unsigned CntW    = 20;
  localparam int unsigned CumW    = 28;   // 256 saturated counts
  localparam int unsigned NumW    = 36;   // 255 * cumulative count
  localparam int unsigned FpW     = 20;

  localparam logic [CntW-1:0] CntMax    = '1;
  localparam logic [LvlW-1:0] OutMax    = 8'd255;
  localparam logic [LvlW-1:0] LvlLast   = 8'd255;
  localparam logic [FpW-1:0]  FpReset   = 20'd120000;

  typedef enum logic [0:0] {
    OP_COUNT = 1'b0,
    OP_MAP   = 1'b1
  } op_e;

  typedef struct packed {
    logic            op;
    logic [LvlW-1:0] chan0_in;
    logic [LvlW-1:0] chan1_in;
    logic [LvlW-1:0] chan2_in;
  } in_word_t;

  typedef struct packed {
    logic [LvlW-1:0] chan0_out;
    logic [LvlW-1:0] chan1_out;
    logic [LvlW-1:0] chan2_out;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ design/histogram_equalizer_rgb.sv @@
// ----------------------------------------------------------------------------
// histogram_equalizer_rgb
// Two-pass histogram equalizer for three 8-bit channels.
// ----------------------------------------------------------------------------
// A count word reads, then saturating-writes back, one table entry per
// channel. A map word goes through table read, scale by 255, nine steps of
// the shared-control divider, a wait for the divider's registered done flag,
// and output load; it takes longer while the previous output word is
// still stalled. The first map word after counting is stalled
// while the tables are turned into cumulative counts in place; the first
// count word after mapping is stalled while the tables are
// cleared. After reset the block clears the tables before
// taking any word; configuration writes are taken at any time.
`include "assert_macros.svh"

module histogram_equalizer_rgb (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [19:0]           cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  heq_pkg::in_word_t     in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output heq_pkg::out_word_t    out_word_o
);
  import heq_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_CLEAR   = 7'b0000010,
    ST_BUILD   = 7'b0000100,
    ST_CNT_WR  = 7'b0001000,
    ST_MAP_RD  = 7'b0010000,
    ST_MAP_DIV = 7'b0100000,
    ST_MAP_OUT = 7'b1000000
  } state_e;

  state_e                       state_q, state_d;
  logic                         phase_q, phase_d;
  logic [8:0]                   sweep_q, sweep_d;
  logic [FpW-1:0]               fp_q;
  logic [NumChan-1:0][LvlW-1:0] addr_q, addr_d;
  logic [NumChan-1:0][CumW-1:0] acc_q, acc_d;
  logic                         out_valid_q, out_valid_d;
  out_word_t                    out_word_q, out_word_d;

  logic                         we, re;
  logic [NumChan-1:0][LvlW-1:0] waddr, raddr, pix;
  logic [NumChan-1:0][CumW-1:0] wdata, rdata;
  logic [NumChan-1:0][NumW-1:0] num;
  logic [NumChan-1:0][LvlW-1:0] quo;
  logic                         div_start, in_acc;
  div_stat_t                    div_stat;

  assign pix[0] = in_word_i.chan0_in;
  assign pix[1] = in_word_i.chan1_in;
  assign pix[2] = in_word_i.chan2_in;

  // Take a word only when the tables are in the pass it needs.
  assign in_stall_o = !((state_q == ST_IDLE) &&
                        ((in_word_i.op == OP_COUNT && !phase_q) ||
                         (in_word_i.op == OP_MAP && phase_q)));
  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      num[c] = ({{(NumW-CumW){1'b0}}, rdata[c]} << 8) - {{(NumW-CumW){1'b0}}, rdata[c]};
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    sweep_d     = sweep_q;
    addr_d      = addr_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = addr_q;
    raddr       = pix;
    wdata       = '0;
    div_start   = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          re      = 1'b1;
          addr_d  = pix;
          state_d = (in_word_i.op == OP_MAP) ? ST_MAP_RD : ST_CNT_WR;
        end else if (in_valid_i) begin
          sweep_d = '0;
          acc_d   = '0;
          state_d = (in_word_i.op == OP_MAP) ? ST_BUILD : ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        we = 1'b1;
        for (int c = 0; c < NumChan; c++) begin
          waddr[c] = sweep_q[LvlW-1:0];
        end
        sweep_d = sweep_q + 9'd1;
        if (sweep_q[LvlW-1:0] == LvlLast) begin
          phase_d = 1'b0;
          sweep_d = '0;
          state_d = ST_IDLE;
        end
      end
      ST_BUILD: begin
        // Read level k while writing the running sum of level k-1.
        for (int c = 0; c < NumChan; c++) begin
          raddr[c] = sweep_q[LvlW-1:0];
          waddr[c] = sweep_q[LvlW-1:0] - 8'd1;
          wdata[c] = acc_q[c] + rdata[c];
        end
        re = !sweep_q[8];
        if (sweep_q != 9'd0) begin
          we    = 1'b1;
          acc_d = wdata;
        end
        sweep_d = sweep_q + 9'd1;
        if (sweep_q[8]) begin
          phase_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_CNT_WR: begin
        we = 1'b1;
        for (int c = 0; c < NumChan; c++) begin
          wdata[c] = (rdata[c][CntW-1:0] == CntMax) ? rdata[c]
                                                   : rdata[c] + {{(CumW-1){1'b0}}, 1'b1};
        end
        state_d = ST_IDLE;
      end
      ST_MAP_RD: begin
        div_start = 1'b1;
        state_d   = ST_MAP_DIV;
      end
      ST_MAP_DIV: begin
        if (div_stat.done) begin
          state_d = ST_MAP_OUT;
        end
      end
      ST_MAP_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_word_d.chan0_out = quo[0];
          out_word_d.chan1_out = quo[1];
          out_word_d.chan2_out = quo[2];
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      phase_q     <= 1'b0;
      sweep_q     <= '0;
      fp_q        <= FpReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        fp_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    acc_q      <= acc_d;
    out_word_q <= out_word_d;
  end

  for (genvar c = 0; c < NumChan; c++) begin : g_tab
    heq_ram u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr[c]),
      .wdata_i (wdata[c]),
      .re_i    (re),
      .raddr_i (raddr[c]),
      .rdata_o (rdata[c])
    );
  end

  heq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (fp_q),
    .stat_o  (div_stat),
    .quo_o   (quo)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `HEQ_ASSERT(a_acc_idle, in_acc |-> state_q == ST_IDLE, "word taken outside idle")
  `HEQ_ASSERT(a_cnt_phase, state_q == ST_CNT_WR |-> !phase_q, "count write in map pass")
  `HEQ_ASSERT(a_div_done, div_stat.done |-> state_q == ST_MAP_DIV, "stray divider done")
  `HEQ_ASSERT(a_div_busy, div_stat.busy |-> state_q == ST_MAP_DIV, "divider busy outside map")
  `HEQ_ASSERT(a_clr_end, (state_q == ST_CLEAR && sweep_q[LvlW-1:0] == LvlLast) |=> !phase_q,
              "clear pass left map pass set")

endmodule

@@ design/heq_ram.sv @@
// ----------------------------------------------------------------------------
// heq_ram
// One channel's level table: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module heq_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [heq_pkg::LvlW-1:0]   waddr_i,
  input  logic [heq_pkg::CumW-1:0]   wdata_i,
  input  logic                       re_i,
  input  logic [heq_pkg::LvlW-1:0]   raddr_i,
  output logic [heq_pkg::CumW-1:0]   rdata_o
);
  import heq_pkg::*;

  logic [CumW-1:0] mem [Levels];
  logic [CumW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/heq_div.sv @@
// ----------------------------------------------------------------------------
// heq_div
// Three-lane restoring divider, one quotient bit per cycle, clipped to 255.
// ----------------------------------------------------------------------------
module heq_div (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  input  logic [heq_pkg::NumChan-1:0][heq_pkg::NumW-1:0] num_i,
  input  logic [heq_pkg::FpW-1:0]                    den_i,
  output heq_pkg::div_stat_t                         stat_o,
  output logic [heq_pkg::NumChan-1:0][heq_pkg::LvlW-1:0] quo_o
);
  import heq_pkg::*;

  logic [NumChan-1:0][NumW-1:0] rem_q, rem_d;
  logic [NumChan-1:0][LvlW-1:0] quo_q, quo_d;
  logic [NumChan-1:0]           sat_q, sat_d;
  logic [3:0]                   bit_q, bit_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [NumW-1:0]              dsh;

  // First step (bit 8) only flags a quotient above 255; a zero divisor lands there too.
  assign dsh = {{(NumW-FpW){1'b0}}, den_i} << bit_q;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    sat_d  = sat_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i;
      quo_d  = '0;
      sat_d  = '0;
      bit_d  = 4'd8;
      busy_d = 1'b1;
    end else if (busy_q) begin
      for (int c = 0; c < NumChan; c++) begin
        if (rem_q[c] >= dsh) begin
          if (bit_q == 4'd8) begin
            sat_d[c] = 1'b1;
          end else begin
            rem_d[c]            = rem_q[c] - dsh;
            quo_d[c][bit_q[2:0]] = 1'b1;
          end
        end
      end
      if (bit_q == 4'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        bit_d = bit_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      bit_q  <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    sat_q <= sat_d;
  end

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      quo_o[c] = sat_q[c] ? OutMax : quo_q[c];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
